>>> src/rdc_pkg.sv
// ----------------------------------------------------------------------------
// Radix digit converter package
// Shared widths, defaults, controller/datapath interface types and the
// digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package rdc_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_DIGITS_DEF  = 32;

	// quotient bits resolved per division cycle
	localparam int BITS_PER_STEP = 8;

	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W  = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;  // '0'
	localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd55;  // 'A' - 10

	typedef struct packed {
		logic load;         // take a new item
		logic digit_start;  // clear remainder and step count for the next digit
		logic step;         // run one division step
		logic read;         // fetch the next digit from the store
		logic emit;         // move the fetched digit into the output register
	} rdc_cmd_t;

	typedef struct packed {
		logic step_last;    // this division cycle completes a digit
		logic quot_zero;    // quotient has run out
		logic cnt_full;     // digit store is full
		logic cnt_one;      // one digit left to emit
		logic out_free;     // output register can take a digit this cycle
	} rdc_sts_t;

	function automatic logic [CHAR_W-1:0] rdc_glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = CHAR_W'(d);
		if (d < 4'd10)
			return CHAR_ZERO + dx;
		else
			return CHAR_LETTER + dx;
	endfunction

endpackage

>>> src/rdc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered and held
// while no read is requested.
// ----------------------------------------------------------------------------
module rdc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> src/rdc_datapath.sv
// ----------------------------------------------------------------------------
// Radix digit converter datapath
// Shift-register long division by the base (eight quotient bits a cycle),
// digit store, digit counter and the output register.
// ----------------------------------------------------------------------------
module rdc_datapath #(
	parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rdc_pkg::rdc_cmd_t            cmd,
	output rdc_pkg::rdc_sts_t            sts,
	input  logic [VALUE_WIDTH-1:0]       value,
	input  logic [rdc_pkg::RADIX_W-1:0]  radix,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rdc_pkg::CHAR_W-1:0]   digit_char,
	output logic                         last_digit
);

	import rdc_pkg::*;

	localparam int STEPS  = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
	localparam int PAD_W  = STEPS * BITS_PER_STEP;
	localparam int STEP_W = $clog2(STEPS + 1);
	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int AW     = $clog2(MAX_DIGITS);

	logic [PAD_W-1:0]         quot_q, quot_next;
	logic [DIGIT_W-1:0]       rem_q, rem_next;
	logic [RADIX_W-1:0]       radix_q, radix_sat;
	logic [STEP_W-1:0]        step_q;
	logic [CNT_W-1:0]         cnt_q, cnt_dec;
	logic [BITS_PER_STEP-1:0] qbits;
	logic                     wr_en;
	logic [DIGIT_W-1:0]       rd_data;
	logic                     out_valid_q, last_q;
	logic [CHAR_W-1:0]        char_q;

	always_comb begin
		if (radix < RADIX_MIN)
			radix_sat = RADIX_MIN;
		else if (radix > RADIX_MAX)
			radix_sat = RADIX_MAX;
		else
			radix_sat = radix;
	end

	// restoring division, one quotient bit per stage
	always_comb begin
		logic [DIGIT_W:0]   t;
		logic [DIGIT_W-1:0] r;
		r     = rem_q;
		t     = '0;
		qbits = '0;
		for (int i = 0; i < BITS_PER_STEP; i++) begin
			t = {r, quot_q[PAD_W-1-i]};
			if (t >= radix_q) begin
				qbits[BITS_PER_STEP-1-i] = 1'b1;
				r = DIGIT_W'(t - radix_q);
			end else begin
				r = t[DIGIT_W-1:0];
			end
		end
		rem_next  = r;
		quot_next = (quot_q << BITS_PER_STEP) | PAD_W'(qbits);
	end

	assign cnt_dec = cnt_q - CNT_W'(1);
	assign wr_en   = cmd.step && sts.step_last;

	assign sts.step_last = (step_q == STEP_W'(STEPS - 1));
	assign sts.quot_zero = (quot_q == '0);
	assign sts.cnt_full  = (cnt_q == CNT_W'(MAX_DIGITS));
	assign sts.cnt_one   = (cnt_q == CNT_W'(1));
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			quot_q  <= PAD_W'(value);
			radix_q <= radix_sat;
			rem_q   <= '0;
		end else if (cmd.digit_start) begin
			rem_q <= '0;
		end else if (cmd.step) begin
			quot_q <= quot_next;
			// carry the remainder into the next step; digit_start clears it per digit
			rem_q  <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.load) begin
			step_q <= '0;
			cnt_q  <= '0;
		end else if (cmd.digit_start) begin
			step_q <= '0;
		end else if (cmd.step) begin
			if (sts.step_last) begin
				step_q <= '0;
				cnt_q  <= cnt_q + CNT_W'(1);
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end else if (cmd.emit) begin
			cnt_q <= cnt_dec;
		end
	end

	rdc_ram #(
		.WIDTH (DIGIT_W),
		.DEPTH (MAX_DIGITS)
	) u_digit_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (rem_next),
		.rd_en   (cmd.read),
		.rd_addr (cnt_dec[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q <= rdc_glyph(rd_data);
			last_q <= sts.cnt_one;
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = char_q;
	assign last_digit = last_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("digit emitted over an untaken transfer");

	a_wr_room: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !sts.cnt_full)
		else $error("digit store written past its depth");

	a_emit_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (cnt_q != '0))
		else $error("digit emitted with an empty store");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (step_q <= STEP_W'(STEPS - 1)))
		else $error("division step count out of range");

endmodule

>>> src/rdc_ctrl.sv
// ----------------------------------------------------------------------------
// Radix digit converter controller
// Sequences load, per-digit division passes, and reverse-order emission
// of the stored digits.
// ----------------------------------------------------------------------------
module rdc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rdc_pkg::rdc_sts_t sts,
	output rdc_pkg::rdc_cmd_t cmd
);

	import rdc_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_DIV   = 5'b00010,
		S_CHECK = 5'b00100,
		S_RD    = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DIV;
				end
			end
			S_DIV: begin
				cmd.step = 1'b1;
				if (sts.step_last)
					state_d = S_CHECK;
			end
			S_CHECK: begin
				// stop once the quotient is gone or the store is full
				if (sts.quot_zero || sts.cnt_full) begin
					state_d = S_RD;
				end else begin
					cmd.digit_start = 1'b1;
					state_d         = S_DIV;
				end
			end
			S_RD: begin
				cmd.read = 1'b1;
				state_d  = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = sts.cnt_one ? S_IDLE : S_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

>>> src/radix_digit_converter_top.sv
// ----------------------------------------------------------------------------
// Radix digit converter
// Converts an unsigned value into ASCII digits of a base from 2 to 16,
// most significant first, flagging the final character of each run.
// ----------------------------------------------------------------------------
// Flow: a run has 1..MAX_DIGITS characters; a new input is taken only in idle,
//   once the last character of the run is in the output register. The
//   division resolves eight quotient bits a cycle and the digit store has
//   one read port.
// Reset: arst_n clears the controller, counters and output valid; the digit
//   store is not cleared, every conversion writes each entry before reading it.
module radix_digit_converter_top #(
	parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [VALUE_WIDTH-1:0]      value,
	input  logic [rdc_pkg::RADIX_W-1:0] radix,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rdc_pkg::CHAR_W-1:0]  digit_char,
	output logic                        last_digit
);

	import rdc_pkg::*;

	rdc_cmd_t cmd;
	rdc_sts_t sts;

	rdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rdc_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.value      (value),
		.radix      (radix),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.digit_char (digit_char),
		.last_digit (last_digit)
	);

endmodule
